### design/mdpf_pkg.sv
// Shared types, constants and codes for the mesh duplicate packet filter.
package mdpf_pkg;

    // Table geometry default
    localparam int DEFAULT_TABLE_DEPTH = 128;

    // Packet word layout
    localparam int WORD_W      = 64;
    localparam int MARKER_W    = 8;
    localparam int MARKER_LSB  = 56;
    localparam int SOURCE_W    = 32;
    localparam int SOURCE_LSB  = 24;
    localparam int SENSOR_W    = 24;
    localparam int VERDICT_W   = 2;
    localparam int OUT_TDATA_W = 64;

    localparam logic [MARKER_W-1:0] MARKER_RESET = 8'hCE;

    // Verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_FORWARD    = 2'd0,
        VERDICT_DUPLICATE  = 2'd1,
        VERDICT_BAD_MARKER = 2'd2,
        VERDICT_LOCAL      = 2'd3
    } t_verdict;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DECIDE = 3'b100
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted input transfer
        logic search;   // step the table scan
        logic decide;   // resolve, append and load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic search_done;  // every filled entry has been compared
        logic out_free;     // output register can take a result this cycle
    } t_status;

endpackage

### design/mdpf_ctrl.sv
// Controller state machine: accept, scan the table, then resolve one word.
module mdpf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mdpf_pkg::t_status i_status,
    output mdpf_pkg::t_cmd   o_cmd
);

    mdpf_pkg::t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            mdpf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mdpf_pkg::ST_SEARCH;
                end
            end
            mdpf_pkg::ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_status.search_done) begin
                    n_state = mdpf_pkg::ST_DECIDE;
                end
            end
            mdpf_pkg::ST_DECIDE: begin
                if (i_status.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = mdpf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mdpf_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdpf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/mdpf_dp.sv
// Datapath: seen-word table, scan counter, marker register and output register.
module mdpf_dp #(
    parameter int TABLE_DEPTH = mdpf_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mdpf_pkg::MARKER_W-1:0]       i_cfg_wdata,
    input  logic [mdpf_pkg::WORD_W-1:0]         i_word,
    input  logic                                i_action,
    input  mdpf_pkg::t_cmd                      i_cmd,
    output mdpf_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mdpf_pkg::OUT_TDATA_W-1:0]    o_out_data
);

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(TABLE_DEPTH);
    localparam int PAD_W = mdpf_pkg::OUT_TDATA_W - 5 - mdpf_pkg::SOURCE_W
                           - mdpf_pkg::SENSOR_W;

    // Table storage, no reset: only entries below the fill count are read
    logic [mdpf_pkg::WORD_W-1:0] r_mem [TABLE_DEPTH];
    logic [mdpf_pkg::WORD_W-1:0] r_rd_data;

    logic [CNTW-1:0]               r_fill;
    logic [CNTW-1:0]               r_idx;
    logic                          r_rd_vld;
    logic                          r_hit;
    logic [mdpf_pkg::WORD_W-1:0]   r_word;
    logic                          r_action;
    logic [mdpf_pkg::MARKER_W-1:0] r_marker;
    logic                          r_out_valid;
    logic [mdpf_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                  read_en;
    logic                  local_word;
    logic                  dup;
    logic                  marker_ok;
    logic                  want_store;
    logic                  room;
    logic                  do_store;
    mdpf_pkg::t_verdict    verdict;
    logic                  forward;

    // Scan reads one entry per cycle while entries remain
    assign read_en = i_cmd.search && (r_idx < r_fill);

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_mem[r_fill[IDXW-1:0]] <= r_word;
        end
        r_rd_data <= r_mem[r_idx[IDXW-1:0]];
    end

    // Marker configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= mdpf_pkg::MARKER_RESET;
        end else if (i_cfg_we) begin
            r_marker <= i_cfg_wdata;
        end
    end

    // Input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word   <= i_word;
            r_action <= i_action;
        end
    end

    // Scan counter, read pipeline flag and hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else if (i_cmd.load) begin
            // local words skip the scan
            r_idx    <= i_action ? r_fill : '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_rd_vld <= read_en;
            if (read_en) begin
                r_idx <= r_idx + CNTW'(1);
            end
            if (r_rd_vld && (r_rd_data == r_word)) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Verdict logic
    always_comb begin
        local_word = r_action;
        dup        = !local_word && r_hit;
        marker_ok  = (r_word[mdpf_pkg::MARKER_LSB +: mdpf_pkg::MARKER_W] == r_marker);
        want_store = local_word || (!dup && marker_ok);
        room       = (r_fill < DEPTH_CNT);
        do_store   = i_cmd.decide && want_store && room;
        forward    = want_store;
        if (local_word) begin
            verdict = mdpf_pkg::VERDICT_LOCAL;
        end else if (dup) begin
            verdict = mdpf_pkg::VERDICT_DUPLICATE;
        end else if (marker_ok) begin
            verdict = mdpf_pkg::VERDICT_FORWARD;
        end else begin
            verdict = mdpf_pkg::VERDICT_BAD_MARKER;
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (do_store) begin
            r_fill <= r_fill + CNTW'(1);
        end
    end

    // Output register, freed when the receiver takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_out_data <= {
                {PAD_W{1'b0}},
                r_word[mdpf_pkg::SENSOR_W-1:0],
                r_word[mdpf_pkg::SOURCE_LSB +: mdpf_pkg::SOURCE_W],
                want_store && !room,
                want_store && room,
                verdict,
                forward
            };
        end
    end

    assign o_status.search_done = (r_idx >= r_fill) && !r_rd_vld;
    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_out_data           = r_out_data;

endmodule

### design/mesh_duplicate_packet_filter.sv
// Top level of the mesh duplicate packet filter: controller plus datapath.
//
// Usage:
//   Slave stream: s_axis_tdata carries the 64-bit packet word, s_axis_tuser
//   is the action flag (0 received from the radio, 1 locally originated).
//   Master stream: one result transfer per input transfer, fields packed in
//   m_axis_tdata as listed at the port.
//   Config: i_cfg_we writes i_cfg_wdata into the accept marker; write only
//   while the block is idle.
// Flow:
//   A received word scans the filled entries one per cycle through the
//   table's registered read port, then waits in the decide state until the
//   output register is free and resolves. A local word skips the scan.
//   One word is in work at a time; the next input is taken the cycle
//   after the result is loaded.
// Reset: clears the fill count (table empty), the output register and sets
//   the accept marker to 0xCE. Table contents are not cleared.
// Stall: a waiting result sits in the output register while the next word
//   is accepted and scanned; that word waits before resolving until the
//   output register is taken.
module mesh_duplicate_packet_filter #(
    parameter int TABLE_DEPTH = mdpf_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [mdpf_pkg::MARKER_W-1:0]       i_cfg_wdata,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mdpf_pkg::WORD_W-1:0]         s_axis_tdata,   // [63:0] packet_word
    input  logic                                s_axis_tuser,   // [0] action
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] forward, [2:1] verdict, [3] stored, [4] table_full,
    // [36:5] source_id, [60:37] sensor_data, [63:61] zero
    output logic [mdpf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    mdpf_pkg::t_cmd    cmd;
    mdpf_pkg::t_status status;

    mdpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mdpf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_word      (s_axis_tdata),
        .i_action    (s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
